@@ sv/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and byte classification helpers of the UTF-8 to
// UCS-2 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned InIdxWidth  = 15;
   localparam int unsigned UnitWidth   = 16;
   localparam int unsigned LenWidth    = 3;
   localparam int unsigned QueueDepth  = 4;
   localparam int unsigned PtrWidth    = $clog2(QueueDepth);
   localparam int unsigned CountWidth  = $clog2(QueueDepth + 1);

   localparam logic [InIdxWidth-1:0] IndexMax     = '1;
   localparam logic [InIdxWidth-1:0] MaxInReset   = 15'h7fff;
   localparam logic [UnitWidth-1:0]  MaxOutReset  = 16'hffff;

   localparam logic [7:0] ContMask  = 8'hc0;
   localparam logic [7:0] ContTag   = 8'h80;
   localparam logic [7:0] PayMask   = 8'h3f;
   localparam logic [7:0] Lead2Mask = 8'he0;
   localparam logic [7:0] Lead3Mask = 8'hf0;
   localparam logic [7:0] Lead4Mask = 8'hf8;
   localparam logic [7:0] Lead5Mask = 8'hfc;
   localparam logic [7:0] Lead6Mask = 8'hfe;
   localparam logic [7:0] Lead3Min  = 8'he0;
   localparam logic [7:0] Lead4Min  = 8'hf0;
   localparam logic [7:0] Lead5Min  = 8'hf8;
   localparam logic [7:0] Lead6Min  = 8'hfc;
   localparam logic [7:0] Lead2Bad  = 8'hc0;

   localparam logic CsrMaxInBytes  = 1'b0;
   localparam logic CsrMaxOutUnits = 1'b1;

   typedef struct packed {
      logic                 is_end;
      logic [UnitWidth-1:0] code_unit;
      logic [LenWidth-1:0]  seq_len;
      logic [UnitWidth-1:0] unit_count;
      logic                 last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } emit_type;

   function automatic logic is_overlong(input logic [7:0] lead, input logic [7:0] b1);
      logic hit;
      hit = 1'b0;
      if (lead == Lead3Min) hit = (b1 & Lead2Mask) == ContTag;
      else if (lead == Lead4Min) hit = (b1 & Lead3Mask) == ContTag;
      else if (lead == Lead5Min) hit = (b1 & Lead4Mask) == ContTag;
      else if (lead == Lead6Min) hit = (b1 & Lead5Mask) == ContTag;
      return hit;
   endfunction

   function automatic logic [LenWidth-1:0] lead_len(input logic [7:0] b);
      logic [LenWidth-1:0] len;
      len = '0;
      if ((b & Lead2Mask) == Lead2Bad) begin
         if ((b & Lead6Mask) != Lead2Bad) len = 3'd2;
      end else if ((b & Lead3Mask) == Lead3Min) begin
         len = 3'd3;
      end else if ((b & Lead4Mask) == Lead4Min) begin
         len = 3'd4;
      end else if ((b & Lead5Mask) == Lead5Min) begin
         len = 3'd5;
      end else if ((b & Lead6Mask) == Lead6Min) begin
         len = 3'd6;
      end
      return len;
   endfunction

   function automatic logic [7:0] lead_bits(input logic [LenWidth-1:0] len,
                                            input logic [7:0] b);
      logic [7:0] mask;
      mask = 8'h00;
      case (len)
         3'd2:    mask = 8'h1f;
         3'd3:    mask = 8'h0f;
         3'd4:    mask = 8'h07;
         3'd5:    mask = 8'h03;
         3'd6:    mask = 8'h01;
         default: mask = 8'h00;
      endcase
      return b & mask;
   endfunction

endpackage

@@ sv/utf8d_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the open sequence and the string counters, and turns one accepted
// byte combinationally into zero, one or two results.
// ----------------------------------------------------------------------------
module utf8d_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [7:0]                          in_byte,
   input  logic                                end_of_string,
   input  logic [utf8d_pkg::InIdxWidth-1:0]    max_in_bytes,
   input  logic [utf8d_pkg::UnitWidth-1:0]     max_out_units,
   output utf8d_pkg::emit_type                 emit
);
   import utf8d_pkg::*;

   logic [7:0]            lead_ff, lead_in;
   logic [LenWidth-1:0]   need_ff, need_in;
   logic [LenWidth-1:0]   seen_ff, seen_in;
   logic [UnitWidth-1:0]  pv_ff, pv_in;
   logic [InIdxWidth-1:0] index_ff, index_in;
   logic [UnitWidth-1:0]  units_ff, units_in;
   logic                  halted_ff, halted_in;

   logic                  consumed;
   logic                  str_end;
   logic                  unit_hit;
   logic [UnitWidth-1:0]  unit_val;
   logic [LenWidth-1:0]   unit_len;
   logic [LenWidth-1:0]   new_len;
   logic [UnitWidth-1:0]  units_inc;
   result_type            unit_res;
   result_type            end_res;

   assign units_inc = units_ff + 16'd1;
   assign new_len   = lead_len(in_byte);

   always_comb begin
      lead_in   = lead_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      pv_in     = pv_ff;
      index_in  = (index_ff != IndexMax) ? index_ff + 15'd1 : index_ff;
      units_in  = units_ff;
      halted_in = halted_ff;
      consumed  = 1'b0;
      str_end   = 1'b0;
      unit_hit  = 1'b0;
      unit_val  = '0;
      unit_len  = '0;

      if (need_ff != '0) begin
         if ((in_byte & ContMask) == ContTag) begin
            consumed = 1'b1;
            if (seen_ff == 3'd1 && is_overlong(lead_ff, in_byte)) begin
               lead_in = '0;
               need_in = '0;
               seen_in = '0;
               pv_in   = '0;
            end else begin
               pv_in   = {pv_ff[9:0], in_byte[5:0]};
               seen_in = seen_ff + 3'd1;
               if (seen_in >= need_ff) begin
                  unit_hit = 1'b1;
                  unit_val = pv_in;
                  unit_len = need_ff;
                  units_in = units_inc;
                  lead_in  = '0;
                  need_in  = '0;
                  seen_in  = '0;
                  pv_in    = '0;
               end
            end
         end else begin
            lead_in = '0;
            need_in = '0;
            seen_in = '0;
            pv_in   = '0;
         end
      end

      if (!consumed) begin
         if (in_byte == 8'h00) begin
            str_end = 1'b1;
         end else if (!halted_ff) begin
            if (units_ff >= max_out_units || index_ff >= max_in_bytes) begin
               halted_in = 1'b1;
            end else if (!in_byte[7]) begin
               unit_hit = 1'b1;
               unit_val = {8'h00, in_byte};
               unit_len = 3'd1;
               units_in = units_inc;
            end else if (new_len != '0) begin
               lead_in = in_byte;
               need_in = new_len;
               seen_in = 3'd1;
               pv_in   = {8'h00, lead_bits(new_len, in_byte)};
            end
         end
      end

      if (end_of_string) str_end = 1'b1;

      if (str_end) begin
         lead_in   = '0;
         need_in   = '0;
         seen_in   = '0;
         pv_in     = '0;
         index_in  = '0;
         units_in  = '0;
         halted_in = 1'b0;
      end
   end

   always_comb begin
      unit_res.is_end      = 1'b0;
      unit_res.code_unit   = unit_val;
      unit_res.seq_len     = unit_len;
      unit_res.unit_count  = units_inc;
      unit_res.last_of_run = !str_end;

      end_res.is_end       = 1'b1;
      end_res.code_unit    = '0;
      end_res.seq_len      = '0;
      end_res.unit_count   = unit_hit ? units_inc : units_ff;
      end_res.last_of_run  = 1'b1;

      emit.first  = unit_hit ? unit_res : end_res;
      emit.second = end_res;
      if (!accept) emit.count = 2'd0;
      else emit.count = {1'b0, unit_hit} + {1'b0, str_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff   <= '0;
         need_ff   <= '0;
         seen_ff   <= '0;
         pv_ff     <= '0;
         index_ff  <= '0;
         units_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         lead_ff   <= lead_in;
         need_ff   <= need_in;
         seen_ff   <= seen_in;
         pv_ff     <= pv_in;
         index_ff  <= index_in;
         units_ff  <= units_in;
         halted_ff <= halted_in;
      end
   end

endmodule

@@ sv/utf8_to_ucs2_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit
// Decodes a UTF-8 byte stream of 1 to 6 byte forms into 16-bit code units
// and closes each string with an end beat that carries the unit count.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle while the queue has room and answers with
// one result beat per cycle while a beat waits and rsp_ready is high. Each byte
// is decoded in the cycle it is accepted and its results go into a four-entry
// result queue; a byte is accepted whenever that queue has room for two beats.
// A byte that completes a code unit and also ends the string makes two beats,
// and every other byte streams at one per cycle while rsp_ready stays high.
// The user writes limit registers only while the unit is idle (not enforced).
module utf8_to_ucs2_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_end_of_string,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_is_end,
   output logic [utf8d_pkg::UnitWidth-1:0]    rsp_code_unit,
   output logic [utf8d_pkg::LenWidth-1:0]     rsp_seq_len,
   output logic [utf8d_pkg::UnitWidth-1:0]    rsp_unit_count,
   output logic                               rsp_last_of_run,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [utf8d_pkg::UnitWidth-1:0]    csr_wdata
);
   import utf8d_pkg::*;

   logic [InIdxWidth-1:0] max_in_ff;
   logic [UnitWidth-1:0]  max_out_ff;

   result_type            queue_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  req_accept;
   logic                  rsp_accept;
   emit_type              emit;
   result_type            head;

   assign req_ready  = count_ff <= CountWidth'(QueueDepth - 2);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = count_ff != '0;
   assign rsp_accept = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_in_ff  <= MaxInReset;
         max_out_ff <= MaxOutReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrMaxInBytes:  max_in_ff  <= csr_wdata[InIdxWidth-1:0];
            CsrMaxOutUnits: max_out_ff <= csr_wdata;
            default:        max_out_ff <= max_out_ff;
         endcase
      end
   end

   utf8d_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .max_in_bytes  (max_in_ff),
      .max_out_units (max_out_ff),
      .emit          (emit)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(emit.count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(rsp_accept);
      count_in  = count_ff + CountWidth'(emit.count) - CountWidth'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) queue_ff[wr_ptr_ff] <= emit.first;
      if (emit.count == 2'd2) queue_ff[wr_ptr_ff + PtrWidth'(1)] <= emit.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_is_end      = head.is_end;
   assign rsp_code_unit   = head.code_unit;
   assign rsp_seq_len     = head.seq_len;
   assign rsp_unit_count  = head.unit_count;
   assign rsp_last_of_run = head.last_of_run;

   // The queue never holds more beats than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("result queue overflow");

   // An end beat always closes the run of its byte and carries no code unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_last_of_run && rsp_code_unit == '0 && rsp_seq_len == '0)
      else $error("malformed end beat");

   // A code unit beat always carries a sequence length and a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_seq_len != '0 && rsp_unit_count != '0)
      else $error("malformed code unit beat");

   // An empty queue that takes no byte shows no beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 && !req_accept |=> !rsp_valid)
      else $error("beat appeared without a byte");

endmodule
